@@ rtl/core/clst_pkg.sv @@
// Shared types and constants for the client last-seen table.
`default_nettype none
package clst_pkg;

	// table geometry
	localparam int DEPTH  = 64;
	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);

	// field widths of the stream words and registers
	localparam int HOST_W    = 32;
	localparam int TIME_W    = 32;
	localparam int EXP_W     = 22;
	localparam int MINUTES_W = 16;
	localparam int MAXC_W    = 7;
	localparam int OUTC_W    = 2;
	localparam int SLOT_W    = 6;
	localparam int FILL_W    = 7;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 16;
	localparam int IN_DAT_W  = 64;
	localparam int OUT_DAT_W = 16;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_EXPIRY_MINUTES = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_CLIENTS    = 1'b1;

	// register reset values
	localparam logic [MINUTES_W-1:0] EXPIRY_RST = 16'd5;
	localparam logic [MAXC_W-1:0]    MAXC_RST   = 7'd64;

	// result codes
	localparam logic [OUTC_W-1:0] OUTC_REFRESHED = 2'd0;
	localparam logic [OUTC_W-1:0] OUTC_ADDED     = 2'd1;
	localparam logic [OUTC_W-1:0] OUTC_FULL      = 2'd2;

	// one table entry as held in the RAM
	typedef struct packed {
		logic              alerted;
		logic [EXP_W-1:0]  expiry;
		logic [TIME_W-1:0] seen;
		logic [HOST_W-1:0] host;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// controller to datapath
	typedef struct packed {
		logic start;
		logic scan;
		logic resolve;
		logic load_out;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic hit;
		logic miss;
	} status_t;

endpackage
`default_nettype wire

@@ rtl/core/clst_ram.sv @@
// Generic single write port, single read port RAM with registered read.
`default_nettype none
module clst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write on enable
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// register read data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/clst_datapath.sv @@
// Datapath: configuration, entry RAM, search pipeline, count and result words.
`default_nettype none
module clst_datapath (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [clst_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [clst_pkg::CFG_DAT_W-1:0]  cfg_wdata,
	input  wire logic [clst_pkg::IN_DAT_W-1:0]   s_tdata,
	input  wire clst_pkg::cmd_t                  cmd,
	output clst_pkg::status_t                    status,
	output logic      [clst_pkg::OUT_DAT_W-1:0]  m_tdata
);
	import clst_pkg::*;

	localparam int CMP_W = (CNT_W > MAXC_W) ? CNT_W : MAXC_W;

	logic [MINUTES_W-1:0] expiry_minutes_q;
	logic [MAXC_W-1:0]    max_clients_q;
	logic [CNT_W-1:0]     count_q;
	logic [HOST_W-1:0]    addr_q;
	logic [TIME_W-1:0]    now_q;
	logic [CNT_W-1:0]     rd_idx_q;
	logic                 vld_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic [OUTC_W-1:0]    res_outc_q;
	logic [SLOT_W-1:0]    res_slot_q;
	logic [FILL_W-1:0]    res_fill_q;
	logic [OUTC_W-1:0]    out_outc_q;
	logic [SLOT_W-1:0]    out_slot_q;
	logic [FILL_W-1:0]    out_fill_q;

	logic                 issue;
	logic                 hit;
	logic                 miss;
	logic                 room;
	logic [CMP_W-1:0]     max_ext;
	logic [CMP_W-1:0]     limit;
	logic [EXP_W-1:0]     min_ext;
	logic [EXP_W-1:0]     expiry_val;
	entry_t               rd_entry;
	entry_t               wr_entry;
	logic                 ram_we;
	logic [IDX_W-1:0]     ram_waddr;

	// hold the configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expiry_minutes_q <= EXPIRY_RST;
			max_clients_q    <= MAXC_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_EXPIRY_MINUTES: expiry_minutes_q <= cfg_wdata;
				CFG_MAX_CLIENTS:    max_clients_q    <= cfg_wdata[MAXC_W-1:0];
				default: ;
			endcase
		end
	end

	// expiry in seconds: minutes times sixty
	assign min_ext    = EXP_W'(expiry_minutes_q);
	assign expiry_val = (min_ext << 6) - (min_ext << 2);

	// clamp the limit to the table depth
	assign max_ext = CMP_W'(max_clients_q);
	assign limit   = (max_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : max_ext;
	assign room    = CMP_W'(count_q) < limit;

	// search status
	assign issue = cmd.scan && (rd_idx_q < count_q);
	assign hit   = vld_s1 && (rd_entry.host == addr_q);
	assign miss  = !vld_s1 && !(rd_idx_q < count_q);
	assign status.hit  = hit;
	assign status.miss = miss;

	// latch the word and advance the read pointer
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			addr_q   <= s_tdata[HOST_W-1:0];
			now_q    <= s_tdata[HOST_W +: TIME_W];
			rd_idx_q <= '0;
		end else if (issue) begin
			rd_idx_q <= rd_idx_q + CNT_W'(1);
		end
		idx_s1 <= rd_idx_q[IDX_W-1:0];
	end

	// track which read data is live
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (cmd.start) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= issue;
		end
	end

	// refresh on hit, append on miss with room
	always_comb begin
		wr_entry.host    = addr_q;
		wr_entry.seen    = now_q;
		wr_entry.expiry  = expiry_val;
		wr_entry.alerted = hit ? rd_entry.alerted : 1'b0;
		ram_waddr        = hit ? idx_s1 : count_q[IDX_W-1:0];
		ram_we           = cmd.resolve && (hit || room);
	end

	clst_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(DEPTH)
	) u_entry_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(wr_entry),
		.re   (issue),
		.raddr(rd_idx_q[IDX_W-1:0]),
		.rdata(rd_entry)
	);

	// update the fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.resolve && !hit && room) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	// capture the result of the search
	always_ff @(posedge clk) begin
		if (cmd.resolve) begin
			if (hit) begin
				res_outc_q <= OUTC_REFRESHED;
				res_slot_q <= SLOT_W'(idx_s1);
				res_fill_q <= FILL_W'(count_q);
			end else if (room) begin
				res_outc_q <= OUTC_ADDED;
				res_slot_q <= SLOT_W'(count_q);
				res_fill_q <= FILL_W'(count_q + CNT_W'(1));
			end else begin
				res_outc_q <= OUTC_FULL;
				res_slot_q <= '0;
				res_fill_q <= FILL_W'(count_q);
			end
		end
	end

	// load the output word
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_outc_q <= res_outc_q;
			out_slot_q <= res_slot_q;
			out_fill_q <= res_fill_q;
		end
	end

	assign m_tdata = {1'b0, out_fill_q, out_slot_q, out_outc_q};

endmodule
`default_nettype wire

@@ rtl/core/clst_ctrl.sv @@
// Controller: sequences accept, search, resolve and output hand-off.
`default_nettype none
module clst_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	input  wire clst_pkg::status_t   status,
	output clst_pkg::cmd_t           cmd
);
	import clst_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   m_tvalid_q;
	logic   out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign out_free = !m_tvalid_q || m_tready;

	// drive datapath commands from the state
	always_comb begin
		cmd          = '0;
		cmd.start    = (state_q == ST_IDLE) && s_tvalid;
		cmd.scan     = (state_q == ST_SCAN);
		cmd.resolve  = (state_q == ST_SCAN) && (status.hit || status.miss);
		cmd.load_out = (state_q == ST_DONE) && out_free;
	end

	// hold state and the output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (status.hit || status.miss) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/client_last_seen_table_core.sv @@
// Top level of the client last-seen table: controller plus datapath.
// A word hitting entry i is resolved when the scan reaches that entry; a miss is resolved
// once every filled entry has been read, or with no read when the table is empty.
// One word at a time: a new word is accepted only after the last result is loaded into the
// output register. The scan takes one entry per cycle through the entry RAM read port, and
// the finished word may wait for the output register to free up.
// Reset clears the fill count and loads expiry_minutes = 5, max_clients = 64;
// entry contents stay undefined and need no clearing pass, as only filled entries are read.
`default_nettype none
module client_last_seen_table_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [clst_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [clst_pkg::CFG_DAT_W-1:0]  cfg_wdata,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [clst_pkg::IN_DAT_W-1:0]   s_tdata,  // host_addr[31:0], now_seconds[63:32]
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic      [clst_pkg::OUT_DAT_W-1:0]  m_tdata   // outcome[1:0], slot[7:2], filled[14:8]
);
	import clst_pkg::*;

	cmd_t    cmd;
	status_t status;

	clst_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.status  (status),
		.cmd     (cmd)
	);

	clst_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tdata  (s_tdata),
		.cmd      (cmd),
		.status   (status),
		.m_tdata  (m_tdata)
	);

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
// Self-checking testbench for the client last-seen table: directed script then random traffic.
`timescale 1ns / 1ps

module tb_top;
	import clst_pkg::*;

	localparam int LIMIT_CYCLES = 1000000;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 80;
	localparam int SCRIPT_ROWS  = 25;
	localparam int PHASES       = 5;

	// one expected result word
	typedef struct packed {
		logic [OUTC_W-1:0] outcome;
		logic [SLOT_W-1:0] slot;
		logic [FILL_W-1:0] filled;
	} verdict_t;

	typedef enum logic {ROW_CFG, ROW_WORD} row_kind_t;

	// one line of the directed script; want is used only where typed is set
	typedef struct packed {
		row_kind_t              kind;
		logic [CFG_IDX_W-1:0]   cfg_idx;
		logic [CFG_DAT_W-1:0]   cfg_data;
		logic [HOST_W-1:0]      host;
		logic [TIME_W-1:0]      now;
		logic                   typed;
		verdict_t               want;
	} script_row_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DAT_W-1:0]   cfg_wdata = '0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [IN_DAT_W-1:0]    s_tdata   = '0;  // host_addr[31:0], now_seconds[63:32]
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_DAT_W-1:0]   m_tdata;        // outcome[1:0], slot[7:2], filled[14:8]

	// predictor copy of the table and its registers
	logic [HOST_W-1:0]      host_copy    [DEPTH];
	logic [TIME_W-1:0]      seen_copy    [DEPTH];
	logic [EXP_W-1:0]       expiry_copy  [DEPTH];
	logic                   alerted_copy [DEPTH];
	logic [CNT_W-1:0]       fill_count   = '0;
	logic [MINUTES_W-1:0]   expiry_minutes = EXPIRY_RST;
	logic [MAXC_W-1:0]      client_limit   = MAXC_RST;

	verdict_t               pending_verdicts [$];
	int                     mismatch_count = 0;
	int                     result_index   = 0;
	int                     burst_left     = 0;
	int                     cycle_count    = 0;
	bit                     hold_req       = 1'b0;

	script_row_t script [SCRIPT_ROWS] = '{
		'{ROW_CFG,  CFG_MAX_CLIENTS,    16'd0,    32'h0, 32'h0, 1'b0, '0},
		'{ROW_WORD, 1'b0, 16'h0, 32'h00000000, 32'h00000000, 1'b1, '{OUTC_FULL, 6'd0, 7'd0}},
		'{ROW_WORD, 1'b0, 16'h0, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, '{OUTC_FULL, 6'd0, 7'd0}},
		'{ROW_CFG,  CFG_MAX_CLIENTS,    16'd3,    32'h0, 32'h0, 1'b0, '0},
		'{ROW_WORD, 1'b0, 16'h0, 32'h00000000, 32'h00000000, 1'b1, '{OUTC_ADDED, 6'd0, 7'd1}},
		'{ROW_WORD, 1'b0, 16'h0, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, '{OUTC_ADDED, 6'd1, 7'd2}},
		'{ROW_WORD, 1'b0, 16'h0, 32'h00000000, 32'h12345678, 1'b1,
			'{OUTC_REFRESHED, 6'd0, 7'd2}},
		'{ROW_WORD, 1'b0, 16'h0, 32'h80000001, 32'h00000001, 1'b1, '{OUTC_ADDED, 6'd2, 7'd3}},
		'{ROW_WORD, 1'b0, 16'h0, 32'h00000001, 32'h00000002, 1'b1, '{OUTC_FULL, 6'd0, 7'd3}},
		'{ROW_WORD, 1'b0, 16'h0, 32'h7FFFFFFF, 32'h00000003, 1'b1, '{OUTC_FULL, 6'd0, 7'd3}},
		'{ROW_WORD, 1'b0, 16'h0, 32'h80000001, 32'h80000000, 1'b1,
			'{OUTC_REFRESHED, 6'd2, 7'd3}},
		'{ROW_CFG,  CFG_EXPIRY_MINUTES, 16'd0,    32'h0, 32'h0, 1'b0, '0},
		'{ROW_WORD, 1'b0, 16'h0, 32'hFFFFFFFF, 32'h00000005, 1'b1,
			'{OUTC_REFRESHED, 6'd1, 7'd3}},
		'{ROW_CFG,  CFG_EXPIRY_MINUTES, 16'hFFFF, 32'h0, 32'h0, 1'b0, '0},
		'{ROW_WORD, 1'b0, 16'h0, 32'hFFFFFFFF, 32'h00000006, 1'b1,
			'{OUTC_REFRESHED, 6'd1, 7'd3}},
		// limit lowered below the count: old entries still hit, new ones are refused
		'{ROW_CFG,  CFG_MAX_CLIENTS,    16'd1,    32'h0, 32'h0, 1'b0, '0},
		'{ROW_WORD, 1'b0, 16'h0, 32'h00000000, 32'h00000007, 1'b1,
			'{OUTC_REFRESHED, 6'd0, 7'd3}},
		'{ROW_WORD, 1'b0, 16'h0, 32'h12345678, 32'h00000008, 1'b1, '{OUTC_FULL, 6'd0, 7'd3}},
		// limit above the depth acts as the depth
		'{ROW_CFG,  CFG_MAX_CLIENTS,    16'hFFFF, 32'h0, 32'h0, 1'b0, '0},
		'{ROW_WORD, 1'b0, 16'h0, 32'h12345678, 32'h00000009, 1'b1, '{OUTC_ADDED, 6'd3, 7'd4}},
		'{ROW_WORD, 1'b0, 16'h0, 32'hA5A5A5A5, 32'hDEADBEEF, 1'b0, '0},
		'{ROW_WORD, 1'b0, 16'h0, 32'h5A5A5A5A, 32'h00000000, 1'b0, '0},
		'{ROW_WORD, 1'b0, 16'h0, 32'hA5A5A5A5, 32'hFFFFFFFE, 1'b0, '0},
		'{ROW_CFG,  CFG_MAX_CLIENTS,    16'd64,   32'h0, 32'h0, 1'b0, '0},
		'{ROW_WORD, 1'b0, 16'h0, 32'h80000001, 32'h55555555, 1'b0, '0}
	};

	// register settings and traffic mix of the random phases
	int phase_limit  [PHASES] = '{20, 10, 127, 64, 0};
	int phase_expiry [PHASES] = '{0, 65535, 77, 1, 5};
	int phase_hits   [PHASES] = '{50, 60, 40, 60, 50};

	client_last_seen_table_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #5 clk = ~clk;

	// search the table copy, then refresh, append or refuse
	function automatic verdict_t learn_host(input logic [HOST_W-1:0] host,
			input logic [TIME_W-1:0] now);
		verdict_t v;
		int       lim;
		int       hit;
		lim = (client_limit > DEPTH) ? DEPTH : int'(client_limit);
		hit = -1;
		for (int i = 0; i < int'(fill_count); i++)
			if (hit < 0 && host_copy[i] == host)
				hit = i;
		if (hit >= 0) begin
			seen_copy[hit]   = now;
			expiry_copy[hit] = EXP_W'(int'(expiry_minutes) * 60);
			v = '{OUTC_REFRESHED, SLOT_W'(hit), fill_count};
		end else if (int'(fill_count) < lim) begin
			host_copy[fill_count]    = host;
			seen_copy[fill_count]    = now;
			expiry_copy[fill_count]  = EXP_W'(int'(expiry_minutes) * 60);
			alerted_copy[fill_count] = 1'b0;
			v = '{OUTC_ADDED, SLOT_W'(fill_count), fill_count + 1'b1};
			fill_count = fill_count + 1'b1;
		end else begin
			v = '{OUTC_FULL, '0, fill_count};
		end
		return v;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH result %0d: %s", result_index, msg);
		mismatch_count++;
	endtask

	// offer one word in bursts with random gaps; record its expectation on acceptance
	task automatic send_word(input logic [HOST_W-1:0] host, input logic [TIME_W-1:0] now,
			input logic typed, input verdict_t want);
		int       gap;
		verdict_t predicted;
		if (burst_left == 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4);
			repeat (gap - 1) @(negedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 16);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {now, host};
		do @(posedge clk); while (!s_tready);
		predicted = learn_host(host, now);
		pending_verdicts.push_back(typed ? want : predicted);
		burst_left--;
	endtask

	// drop valid and wait until every result has come back
	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_verdicts.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we    <= 1'b0;
		if (idx == CFG_EXPIRY_MINUTES)
			expiry_minutes = data;
		else
			client_limit = data[MAXC_W-1:0];
	endtask

	// known hosts at hit_pct percent, ten percent one-bit neighbours of them, the rest fresh addresses
	task automatic run_phase(input int count, input int hit_pct, input bit with_hold);
		logic [HOST_W-1:0] host;
		int                pick;
		for (int n = 0; n < count; n++) begin
			if (with_hold && n == count / 4)
				hold_req = 1'b1;
			pick = $urandom_range(0, 99);
			if (fill_count != 0 && pick < hit_pct)
				host = host_copy[$urandom_range(0, fill_count - 1)];
			else if (fill_count != 0 && pick < hit_pct + 10)
				host = host_copy[$urandom_range(0, fill_count - 1)]
					^ (32'h1 << $urandom_range(0, 31));
			else
				host = $urandom;
			send_word(host, $urandom, 1'b0, '0);
		end
	endtask

	// receiver: ready runs broken by short stalls, plus one long hold on request
	initial begin : receiver
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(negedge clk);
				if ($urandom_range(0, 3) != 0) begin
					m_tready <= 1'b0;
					repeat ($urandom_range(1, 6)) @(negedge clk);
				end
			end
		end
	end

	// compare each accepted result word with the oldest expectation
	always @(posedge clk) begin : check_results
		verdict_t want;
		verdict_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{m_tdata[1:0], m_tdata[7:2], m_tdata[14:8]};
			if (pending_verdicts.size() == 0) begin
				report_mismatch($sformatf("unexpected word %h", m_tdata));
			end else begin
				want = pending_verdicts.pop_front();
				if (got.outcome != want.outcome)
					report_mismatch($sformatf("outcome got %0d, expected %0d",
						got.outcome, want.outcome));
				if (got.slot != want.slot)
					report_mismatch($sformatf("slot got %0d, expected %0d",
						got.slot, want.slot));
				if (got.filled != want.filled)
					report_mismatch($sformatf("filled got %0d, expected %0d",
						got.filled, want.filled));
			end
			result_index++;
		end
	end

	// guard against a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin : stimulus
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// directed script
		for (int r = 0; r < SCRIPT_ROWS; r++) begin
			if (script[r].kind == ROW_CFG) begin
				wait_idle();
				write_reg(script[r].cfg_idx, script[r].cfg_data);
			end else begin
				send_word(script[r].host, script[r].now, script[r].typed, script[r].want);
			end
		end

		// random phases, each under its own register settings
		for (int p = 0; p < PHASES; p++) begin
			wait_idle();
			write_reg(CFG_MAX_CLIENTS, CFG_DAT_W'(phase_limit[p]));
			write_reg(CFG_EXPIRY_MINUTES, CFG_DAT_W'(phase_expiry[p]));
			run_phase(310, phase_hits[p], p == 1);
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/clst_pkg.sv
rtl/core/clst_ram.sv
rtl/core/clst_datapath.sv
rtl/core/clst_ctrl.sv
rtl/core/client_last_seen_table_core.sv
sim/tb_top.sv
